### rtl/dslr_pkg.sv
// dslr_pkg: widths, constants and lane control types for the dual servo ramp core.
// No dependencies; used by every other file of the block.

package dslr_pkg;

  localparam int ANGLE_W    = 8;
  localparam int COUNT_W    = 10;
  localparam int DUTY_OUT_W = 11;
  localparam int DIV_W      = 11;

  localparam int DUTY_FULL_SCALE_DEF = 10000;
  localparam int FRACTION_BITS_DEF   = 8;

  // 50 Hz frame: 0.5 ms .. 2.5 ms over 0..180 degrees -> (45 + angle) / 1800 of a frame
  localparam int DUTY_OFFSET  = 45;
  localparam int DUTY_DIVISOR = 1800;
  localparam int DUTY_SAT     = 2047;

  localparam logic [ANGLE_W-1:0] SETTLED_A_RST = 8'd151;
  localparam logic [ANGLE_W-1:0] SETTLED_B_RST = 8'd134;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic load_move;
    logic advance;
    logic load_duty;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic near;
  } lane_stat_t;

endpackage

### rtl/dslr_ifs.sv
// dslr_ifs: valid/ready channel interfaces for commands and results.
// Depends on dslr_pkg for field widths.

interface dslr_cmd_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [dslr_pkg::ANGLE_W-1:0]    target_a;
  logic [dslr_pkg::ANGLE_W-1:0]    target_b;
  logic [dslr_pkg::COUNT_W-1:0]    step_count;

  modport source (output valid, command, target_a, target_b, step_count, input ready);
  modport sink   (input valid, command, target_a, target_b, step_count, output ready);
endinterface

interface dslr_res_if;
  logic                            valid;
  logic                            ready;
  logic [dslr_pkg::DUTY_OUT_W-1:0] duty_a;
  logic [dslr_pkg::DUTY_OUT_W-1:0] duty_b;
  logic                            done_res;

  modport source (output valid, duty_a, duty_b, done_res, input ready);
  modport sink   (input valid, duty_a, duty_b, done_res, output ready);
endinterface

### rtl/dslr_serdiv.sv
// dslr_serdiv: restoring divider, one quotient bit per cycle through a shift register.
// Depends on dslr_pkg for the divisor width.

module dslr_serdiv #(
  parameter int DW = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [dslr_pkg::DIV_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [DW-1:0]               quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [CW-1:0]               cnt;
  logic [dslr_pkg::DIV_W-1:0]  rem;
  logic [dslr_pkg::DIV_W-1:0]  dvs;
  logic [DW-1:0]               dq;
  logic [dslr_pkg::DIV_W:0]    trial;
  logic [dslr_pkg::DIV_W:0]    diff;
  logic                        ge;

  always_comb begin
    trial = {rem, dq[DW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dq   <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[dslr_pkg::DIV_W-1:0] : trial[dslr_pkg::DIV_W-1:0];
        dq  <= {dq[DW-2:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

### rtl/dslr_lane.sv
// dslr_lane: one servo channel: settled angle, ramp position and step, duty value.
// Depends on dslr_pkg and dslr_serdiv (shared for step and duty divisions).

module dslr_lane #(
  parameter int                             FRACTION_BITS   = dslr_pkg::FRACTION_BITS_DEF,
  parameter int                             DUTY_FULL_SCALE = dslr_pkg::DUTY_FULL_SCALE_DEF,
  parameter logic [dslr_pkg::ANGLE_W-1:0]   SETTLED_RST     = dslr_pkg::SETTLED_A_RST
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dslr_pkg::lane_ctrl_t               ctrl,
  input  logic [dslr_pkg::ANGLE_W-1:0]       target,
  input  logic [dslr_pkg::COUNT_W-1:0]       count,
  output dslr_pkg::lane_stat_t               stat,
  output logic [dslr_pkg::DUTY_OUT_W-1:0]    duty
);

  localparam int AW     = dslr_pkg::ANGLE_W;
  localparam int PW     = AW + FRACTION_BITS;
  localparam int DUTY_W = $clog2(DUTY_FULL_SCALE + 1);
  localparam int PROD_W = DUTY_W + AW + 1;
  localparam int DW     = (PW > PROD_W) ? PW : PROD_W;
  localparam logic [DUTY_W-1:0] SCALE = DUTY_W'(DUTY_FULL_SCALE);

  logic [AW-1:0]                      settled;
  logic [AW-1:0]                      hold;
  logic [PW-1:0]                      pos;
  logic [PW-1:0]                      inc_mag;
  logic                               inc_neg;
  logic                               inc_zero;
  logic                               duty_mode;
  logic                               near;

  logic [PW-1:0]                      goal;
  logic [PW-1:0]                      gap;
  logic [PW-1:0]                      pos_step;
  logic [PW-1:0]                      pos_adv;
  logic [AW-1:0]                      start_mag;
  logic [dslr_pkg::COUNT_W-1:0]       cnt_eff;
  logic [AW:0]                        angle_sum;
  logic [PROD_W-1:0]                  prod;
  logic                               div_start;
  logic [DW-1:0]                      div_dividend;
  logic [dslr_pkg::DIV_W-1:0]         div_divisor;
  logic                               div_busy;
  logic                               div_done;
  logic [DW-1:0]                      quot;
  logic [dslr_pkg::DUTY_OUT_W-1:0]    duty_sat;

  always_comb begin
    goal      = {hold, {FRACTION_BITS{1'b0}}};
    gap       = (pos > goal) ? (pos - goal) : (goal - pos);
    pos_step  = inc_neg ? (pos - inc_mag) : (pos + inc_mag);
    pos_adv   = (gap >= inc_mag) ? pos_step : goal;
    start_mag = (target >= settled) ? (target - settled) : (settled - target);
    cnt_eff   = (count == '0) ? dslr_pkg::COUNT_W'(1) : count;
    angle_sum = (AW + 1)'(pos[PW-1:FRACTION_BITS]) + (AW + 1)'(dslr_pkg::DUTY_OFFSET);
    prod      = PROD_W'(SCALE) * PROD_W'(angle_sum);

    div_start    = ctrl.load_move | ctrl.load_duty;
    div_dividend = ctrl.load_duty ? DW'(prod) : DW'({start_mag, {FRACTION_BITS{1'b0}}});
    div_divisor  = ctrl.load_duty ? dslr_pkg::DIV_W'(dslr_pkg::DUTY_DIVISOR)
                                  : dslr_pkg::DIV_W'(cnt_eff);

    duty_sat = (quot > DW'(dslr_pkg::DUTY_SAT)) ? dslr_pkg::DUTY_OUT_W'(dslr_pkg::DUTY_SAT)
                                                 : quot[dslr_pkg::DUTY_OUT_W-1:0];
  end

  dslr_serdiv #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settled <= SETTLED_RST;
    end else begin
      if (ctrl.load_move) begin
        pos       <= {settled, {FRACTION_BITS{1'b0}}};
        hold      <= target;
        inc_neg   <= (target < settled);
        inc_zero  <= (target == settled);
        duty_mode <= 1'b0;
      end
      if (ctrl.advance) begin
        pos <= pos_adv;
      end
      if (ctrl.load_duty) begin
        near      <= (gap[PW-1:FRACTION_BITS] == '0);
        duty_mode <= 1'b1;
      end
      if (div_done) begin
        if (duty_mode) begin
          duty <= duty_sat;
        end else if (inc_zero) begin
          inc_mag <= '0;
        end else if (quot == '0) begin
          inc_mag <= PW'(1);
        end else begin
          inc_mag <= quot[PW-1:0];
        end
      end
      if (ctrl.commit) begin
        settled <= hold;
      end
    end
  end

  assign stat.busy = div_busy | div_done;
  assign stat.near = near;

endmodule

### rtl/dual_servo_linear_ramp_core.sv
// dual_servo_linear_ramp_core: two-channel servo ramp generator, top level.
// Depends on dslr_pkg, dslr_ifs (channels) and dslr_lane.
//
//   port     | kind   | transaction
//   ---------+--------+-----------------------------------------------
//   request  | sink   | command, target_a, target_b, step_count
//   result   | source | duty_a, duty_b, done_res (one per tick while moving)
//
// A move and a live tick each run the bit-serial divider in each lane through DW quotient
// bits, DW being the larger of 8 + FRACTION_BITS and the duty product width. A tick while
// idle changes nothing; it and a move produce no result.
// Reset is synchronous; settled angles return to 151 and 134 degrees.
// A held result does not block a move; a tick waits for the result register to drain.

module dual_servo_linear_ramp_core #(
  parameter int FRACTION_BITS   = dslr_pkg::FRACTION_BITS_DEF,
  parameter int DUTY_FULL_SCALE = dslr_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dslr_cmd_if.sink   request,
  dslr_res_if.source result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_DUTY,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                           state;
  logic                             moving;
  logic                             accept;
  logic                             emit_fire;
  logic                             lanes_busy;
  dslr_pkg::lane_ctrl_t             ctrl;
  dslr_pkg::lane_stat_t             stat_a;
  dslr_pkg::lane_stat_t             stat_b;
  logic [dslr_pkg::DUTY_OUT_W-1:0]  lane_duty_a;
  logic [dslr_pkg::DUTY_OUT_W-1:0]  lane_duty_b;

  assign request.ready = (state == S_IDLE);

  always_comb begin
    accept         = request.valid && request.ready;
    emit_fire      = (state == S_EMIT) && (!result.valid || result.ready);
    lanes_busy     = stat_a.busy | stat_b.busy;
    ctrl.load_move = accept && (request.command == dslr_pkg::CMD_MOVE);
    ctrl.advance   = accept && (request.command == dslr_pkg::CMD_TICK) && moving;
    ctrl.load_duty = (state == S_DUTY);
    ctrl.commit    = emit_fire && stat_a.near && stat_b.near;
  end

  dslr_lane #(
    .FRACTION_BITS   (FRACTION_BITS),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
    .SETTLED_RST     (dslr_pkg::SETTLED_A_RST)
  ) u_lane_a (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .target (request.target_a),
    .count  (request.step_count),
    .stat   (stat_a),
    .duty   (lane_duty_a)
  );

  dslr_lane #(
    .FRACTION_BITS   (FRACTION_BITS),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
    .SETTLED_RST     (dslr_pkg::SETTLED_B_RST)
  ) u_lane_b (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .target (request.target_b),
    .count  (request.step_count),
    .stat   (stat_b),
    .duty   (lane_duty_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      moving       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && !emit_fire) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctrl.load_move) begin
            moving <= 1'b1;
            state  <= S_MOVE;
          end else if (ctrl.advance) begin
            state <= S_DUTY;
          end
        end
        S_MOVE: begin
          if (!lanes_busy) state <= S_IDLE;
        end
        S_DUTY: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!lanes_busy) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            result.valid    <= 1'b1;
            result.duty_a   <= lane_duty_a;
            result.duty_b   <= lane_duty_b;
            result.done_res <= ctrl.commit;
            if (ctrl.commit) moving <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> (!stat_a.busy && !stat_b.busy))
    else $error("command accepted while a lane divider is running");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    stat_a.busy == stat_b.busy)
    else $error("lane dividers out of step");

  a_result_from_move: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(moving))
    else $error("result produced without an active move");

endmodule

### tb/sv/tb_dual_servo_linear_ramp_core.sv
// tb_dual_servo_linear_ramp_core: self-checking bench for the dual servo ramp core.
// Directed and random move/tick transactions, with a predicted duty/done per live tick.
// Depends on dslr_pkg, dslr_ifs and dual_servo_linear_ramp_core.

module tb_dual_servo_linear_ramp_core;

  localparam int FB           = dslr_pkg::FRACTION_BITS_DEF;
  localparam int IDLE_PCT     = 7;
  localparam int ITEM_TARGET  = 550;
  localparam int HOLDOFF_LEN  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CALM_FROM    = 4000;
  localparam int CALM_TO      = 9000;

  typedef struct packed {
    logic                         command;
    logic [dslr_pkg::ANGLE_W-1:0] target_a;
    logic [dslr_pkg::ANGLE_W-1:0] target_b;
    logic [dslr_pkg::COUNT_W-1:0] step_count;
  } servo_cmd_t;

  typedef struct packed {
    logic [dslr_pkg::DUTY_OUT_W-1:0] duty_a;
    logic [dslr_pkg::DUTY_OUT_W-1:0] duty_b;
    logic                            done_res;
  } servo_res_t;

  typedef struct packed {
    logic [dslr_pkg::ANGLE_W-1:0] settled_a;
    logic [dslr_pkg::ANGLE_W-1:0] settled_b;
    logic [dslr_pkg::ANGLE_W-1:0] hold_a;
    logic [dslr_pkg::ANGLE_W-1:0] hold_b;
    logic [31:0]                  pos_a;
    logic [31:0]                  pos_b;
    logic [31:0]                  inc_a;
    logic [31:0]                  inc_b;
    logic                         moving;
  } servo_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cyc = 0;
  int   err_count = 0;
  int   results_seen = 0;
  int   holdoff_left = 0;
  bit   holdoff_used = 0;
  bit   calm;

  int n_moves = 0;
  int n_live_ticks = 0;
  int n_idle_ticks = 0;

  servo_cmd_t   cmd_backlog[$];
  servo_res_t   tick_results_due[$];
  servo_state_t plan_servo;
  servo_state_t live_servo;

  dslr_cmd_if req_if();
  dslr_res_if res_if();

  dual_servo_linear_ramp_core dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  function automatic int ramp_step_size(int from, int to, int cnt);
    int mag;
    int q;
    if (to == from) return 0;
    mag = (to > from) ? to - from : from - to;
    q = (mag << FB) / cnt;
    if (q == 0) q = 1;
    return (to > from) ? q : -q;
  endfunction

  function automatic int ramp_next(int pos, int inc, int tgt);
    int goal;
    int gap;
    int mag;
    goal = tgt << FB;
    gap  = (pos > goal) ? pos - goal : goal - pos;
    mag  = (inc < 0) ? -inc : inc;
    if (gap >= mag) return pos + inc;
    return goal;
  endfunction

  function automatic bit ramp_near(int pos, int tgt);
    int goal;
    int gap;
    goal = tgt << FB;
    gap  = (pos > goal) ? pos - goal : goal - pos;
    return gap < (1 << FB);
  endfunction

  function automatic logic [dslr_pkg::DUTY_OUT_W-1:0] servo_duty(int pos);
    int d;
    d = (dslr_pkg::DUTY_FULL_SCALE_DEF * (dslr_pkg::DUTY_OFFSET + (pos >> FB)))
        / dslr_pkg::DUTY_DIVISOR;
    if (d > dslr_pkg::DUTY_SAT) d = dslr_pkg::DUTY_SAT;
    return d[dslr_pkg::DUTY_OUT_W-1:0];
  endfunction

  task automatic servo_ramp_apply(inout servo_state_t s, input servo_cmd_t c,
                                  output bit has, output servo_res_t r);
    int cnt;
    has = 1'b0;
    r   = '0;
    if (c.command == dslr_pkg::CMD_MOVE) begin
      cnt = (c.step_count == 0) ? 1 : int'(c.step_count);
      s.pos_a  = int'(s.settled_a) << FB;
      s.pos_b  = int'(s.settled_b) << FB;
      s.inc_a  = ramp_step_size(int'(s.settled_a), int'(c.target_a), cnt);
      s.inc_b  = ramp_step_size(int'(s.settled_b), int'(c.target_b), cnt);
      s.hold_a = c.target_a;
      s.hold_b = c.target_b;
      s.moving = 1'b1;
    end else if (s.moving) begin
      s.pos_a = ramp_next(s.pos_a, s.inc_a, int'(s.hold_a));
      s.pos_b = ramp_next(s.pos_b, s.inc_b, int'(s.hold_b));
      r.duty_a   = servo_duty(s.pos_a);
      r.duty_b   = servo_duty(s.pos_b);
      r.done_res = ramp_near(s.pos_a, int'(s.hold_a)) && ramp_near(s.pos_b, int'(s.hold_b));
      if (r.done_res) begin
        s.settled_a = s.hold_a;
        s.settled_b = s.hold_b;
        s.moving    = 1'b0;
      end
      has = 1'b1;
    end
  endtask

  function automatic servo_state_t servo_reset_state();
    servo_state_t s;
    s = '0;
    s.settled_a = dslr_pkg::SETTLED_A_RST;
    s.settled_b = dslr_pkg::SETTLED_B_RST;
    return s;
  endfunction

  task automatic queue_cmd(logic cmd, int ta, int tb, int cnt);
    servo_cmd_t c;
    servo_res_t r;
    bit has;
    c.command    = cmd;
    c.target_a   = ta[dslr_pkg::ANGLE_W-1:0];
    c.target_b   = tb[dslr_pkg::ANGLE_W-1:0];
    c.step_count = cnt[dslr_pkg::COUNT_W-1:0];
    servo_ramp_apply(plan_servo, c, has, r);
    if (cmd == dslr_pkg::CMD_MOVE) n_moves++;
    else if (has) n_live_ticks++;
    else n_idle_ticks++;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_ticks(int limit);
    int k;
    k = 0;
    while (plan_servo.moving && k < limit) begin
      queue_cmd(dslr_pkg::CMD_TICK, $urandom_range(255), $urandom_range(255),
                $urandom_range(1023));
      k++;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_seen);
  endtask

  // command side: predictor runs on every accepted transaction
  always @(posedge clk) begin : cmd_drive
    servo_cmd_t nxt;
    servo_cmd_t taken;
    servo_res_t r;
    bit has;
    if (rst) begin
      req_if.valid      <= 1'b0;
      req_if.command    <= dslr_pkg::CMD_TICK;
      req_if.target_a   <= '0;
      req_if.target_b   <= '0;
      req_if.step_count <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken = {req_if.command, req_if.target_a, req_if.target_b, req_if.step_count};
        servo_ramp_apply(live_servo, taken, has, r);
        if (has) tick_results_due.push_back(r);
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = cmd_backlog.pop_front();
          req_if.command    <= nxt.command;
          req_if.target_a   <= nxt.target_a;
          req_if.target_b   <= nxt.target_b;
          req_if.step_count <= nxt.step_count;
          req_if.valid      <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_used <= 1'b0;
    end else if (!holdoff_used && results_seen >= 120) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_used <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (holdoff_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    servo_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (tick_results_due.size() == 0) begin
        report_mismatch("unexpected result duty_a", res_if.duty_a, 0);
      end else begin
        want = tick_results_due.pop_front();
        if (res_if.duty_a !== want.duty_a)
          report_mismatch("duty_a", res_if.duty_a, want.duty_a);
        if (res_if.duty_b !== want.duty_b)
          report_mismatch("duty_b", res_if.duty_b, want.duty_b);
        if (res_if.done_res !== want.done_res)
          report_mismatch("done_res", res_if.done_res, want.done_res);
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    int cnt;
    int lim;
    plan_servo = servo_reset_state();
    live_servo = servo_reset_state();

    // directed: idle tick, zero count, unit count, no-change move, forced one-LSB steps,
    // abandoned move restarted from settled angles, decreasing ramp
    queue_cmd(dslr_pkg::CMD_TICK, 0, 0, 0);
    queue_cmd(dslr_pkg::CMD_MOVE, 0, 255, 0);
    queue_ticks(4);
    queue_cmd(dslr_pkg::CMD_MOVE, 255, 0, 1);
    queue_ticks(4);
    queue_cmd(dslr_pkg::CMD_MOVE, 255, 0, 5);
    queue_ticks(4);
    queue_cmd(dslr_pkg::CMD_MOVE, 254, 1, 1023);
    queue_ticks(4);
    queue_cmd(dslr_pkg::CMD_MOVE, 180, 180, 1023);
    queue_ticks(3);
    queue_cmd(dslr_pkg::CMD_MOVE, 0, 90, 3);
    queue_ticks(8);
    queue_cmd(dslr_pkg::CMD_MOVE, 10, 200, 7);
    queue_ticks(12);

    while (n_moves + n_live_ticks < ITEM_TARGET) begin
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: cnt = $urandom_range(12);
          7, 8:                cnt = $urandom_range(80, 13);
          default:             cnt = $urandom_range(1023, 81);
        endcase
        if ($urandom_range(3) == 0)
          queue_cmd(dslr_pkg::CMD_MOVE, $urandom_range(180), $urandom_range(180), cnt);
        else
          queue_cmd(dslr_pkg::CMD_MOVE, $urandom_range(255), $urandom_range(255), cnt);
        lim = (cnt > 80) ? $urandom_range(40, 1) : 2000;
        if ($urandom_range(9) == 0) lim = $urandom_range(cnt / 2 + 1);
        queue_ticks(lim);
      end else if ($urandom_range(1) == 0) begin
        queue_cmd(dslr_pkg::CMD_TICK, $urandom_range(255), $urandom_range(255),
                  $urandom_range(1023));
      end else begin
        queue_cmd(dslr_pkg::CMD_MOVE, $urandom_range(255), $urandom_range(255),
                  $urandom_range(1023));
        queue_ticks($urandom_range(5));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || req_if.valid) @(posedge clk);
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d moves, %0d live ticks, %0d ignored idle ticks",
             n_moves, n_live_ticks, n_idle_ticks);
    $display("checked %0d results, including a %0d-cycle result backpressure stretch",
             results_seen, HOLDOFF_LEN);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results still due", tick_results_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
